### rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types, codes and constants shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int BS_W           = 13;
  localparam int OFS_W          = 17;
  localparam int CNT_OUT_W      = 6;
  localparam int REQ_W          = 2;
  localparam int STAT_W         = 2;

  localparam logic [BS_W-1:0] BS_RESET = 13'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_RESET   = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } stat_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [OFS_W-1:0] release_offset;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [OFS_W-1:0]     block_offset;
    logic [CNT_OUT_W-1:0] blocks_in_use;
    logic                 pool_empty;
    logic                 pool_full;
  } out_item_t;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_WALK_START,
    S_WALK,
    S_UNLINK,
    S_PUSH,
    S_SWEEP,
    S_RESP
  } fsm_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ALLOC_RD,
    OP_ALLOC_WR,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_UNLINK,
    OP_PUSH,
    OP_SWEEP,
    OP_FAIL,
    OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    stat_t  fail_code;
  } dp_cmd_t;

  typedef struct packed {
    logic free_avail;
    logic head_end;
    logic hit;
    logic next_end;
    logic sweep_last;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: steps the datapath through allocate, release walk,
// pool rebuild and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [fbpa_pkg::REQ_W-1:0]  in_req_type,
  output logic                             in_ready,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output fbpa_pkg::dp_cmd_t                cmd,
  input  wire fbpa_pkg::dp_sts_t           sts
);
  import fbpa_pkg::*;

  fsm_t state_r, state_nxt;
  logic out_valid_r;
  logic resp_free;

  assign resp_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_BOOT: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        if (sts.sweep_last) state_nxt = S_RESP;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req_type)
            REQ_ALLOC:   state_nxt = S_ALLOC_RD;
            REQ_RELEASE: state_nxt = S_WALK_START;
            REQ_RESET:   state_nxt = S_SWEEP;
            default:     state_nxt = S_RESP;
          endcase
        end
      end
      S_ALLOC_RD:   state_nxt = sts.free_avail ? S_ALLOC_WR : S_RESP;
      S_ALLOC_WR:   state_nxt = S_RESP;
      S_WALK_START: state_nxt = sts.head_end ? S_RESP : S_WALK;
      S_WALK: begin
        priority if (sts.hit) state_nxt = S_UNLINK;
        else if (sts.next_end) state_nxt = S_RESP;
        else state_nxt = S_WALK;
      end
      S_UNLINK: state_nxt = S_PUSH;
      S_PUSH:   state_nxt = S_RESP;
      S_RESP: begin
        if (resp_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    cmd.fail_code = ST_OK;
    unique case (state_r)
      S_BOOT, S_SWEEP: cmd.op = OP_SWEEP;
      S_IDLE: begin
        if (in_valid) cmd.op = OP_ACCEPT;
      end
      S_ALLOC_RD: begin
        if (sts.free_avail) begin
          cmd.op = OP_ALLOC_RD;
        end else begin
          cmd.op        = OP_FAIL;
          cmd.fail_code = ST_FULL;
        end
      end
      S_ALLOC_WR: cmd.op = OP_ALLOC_WR;
      S_WALK_START: begin
        if (sts.head_end) begin
          cmd.op        = OP_FAIL;
          cmd.fail_code = ST_NOT_FOUND;
        end else begin
          cmd.op = OP_WALK_START;
        end
      end
      S_WALK: begin
        // on a hit the read port keeps the link of the matching entry
        priority if (sts.hit) begin
          cmd.op = OP_NONE;
        end else if (sts.next_end) begin
          cmd.op        = OP_FAIL;
          cmd.fail_code = ST_NOT_FOUND;
        end else begin
          cmd.op = OP_WALK_STEP;
        end
      end
      S_UNLINK: cmd.op = OP_UNLINK;
      S_PUSH:   cmd.op = OP_PUSH;
      S_RESP: begin
        if (resp_free) cmd.op = OP_RESP;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.op == OP_RESP) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_resp_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && !out_ready) |=> (state_r == S_RESP))
    else $error("result dropped while output register busy");

  a_resp_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RESP) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

`default_nettype wire

### rtl/core/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: link table memory, list heads, use count, offset multiplier
// and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_dp #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  input  wire logic [fbpa_pkg::BS_W-1:0]   cfg_data,
  input  wire logic [fbpa_pkg::OFS_W-1:0]  in_release_offset,
  input  wire fbpa_pkg::dp_cmd_t           cmd,
  output fbpa_pkg::dp_sts_t                sts,
  output fbpa_pkg::out_item_t              out_data
);
  import fbpa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = (IDX_W + BS_W > OFS_W) ? (IDX_W + BS_W) : OFS_W;
  localparam logic [IDX_W-1:0]  END_MARK = IDX_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BLOCKS);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MAX_BLOCKS - 1);

  logic [IDX_W-1:0] link_mem [MAX_BLOCKS];

  logic [BS_W-1:0]   bsize_r;
  logic [IDX_W-1:0]  free_head_r;
  logic [IDX_W-1:0]  active_head_r;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] sweep_r;

  logic [OFS_W-1:0]  want_r;
  logic [IDX_W-1:0]  cur_r;
  logic [IDX_W-1:0]  prev_r;
  logic [IDX_W-1:0]  rdata_r;
  logic [OFS_W-1:0]  prod_r;
  logic [OFS_W-1:0]  ofs_r;
  stat_t             status_r;
  out_item_t         out_r;

  logic [IDX_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [PROD_W-1:0] prod_full;
  logic              prev_valid;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [IDX_W-1:0]  mem_wdata;

  assign prev_valid = (prev_r < END_MARK);

  // read address also feeds the multiplier so offset and link arrive together
  always_comb begin
    rd_idx = cur_r;
    unique case (cmd.op)
      OP_ALLOC_RD:   rd_idx = free_head_r;
      OP_WALK_START: rd_idx = active_head_r;
      OP_WALK_STEP:  rd_idx = rdata_r;
      default:       rd_idx = cur_r;
    endcase
  end

  assign rd_addr   = rd_idx[ADDR_W-1:0];
  assign prod_full = PROD_W'(rd_idx) * PROD_W'(bsize_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_r[ADDR_W-1:0];
    mem_wdata = active_head_r;
    unique case (cmd.op)
      OP_ALLOC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[ADDR_W-1:0];
        mem_wdata = active_head_r;
      end
      OP_UNLINK: begin
        mem_we    = prev_valid;
        mem_waddr = prev_r[ADDR_W-1:0];
        mem_wdata = rdata_r;
      end
      OP_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[ADDR_W-1:0];
        mem_wdata = free_head_r;
      end
      OP_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = IDX_W'(sweep_r) + IDX_W'(1);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= link_mem[rd_addr];
  end

  assign sts.free_avail = (count_r < CNT_MAX) && (free_head_r < END_MARK);
  assign sts.head_end   = (active_head_r >= END_MARK);
  assign sts.hit        = (prod_r == want_r);
  assign sts.next_end   = (rdata_r >= END_MARK);
  assign sts.sweep_last = (sweep_r == LAST_IDX);

  // list heads, count, block size and rebuild pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r       <= BS_RESET;
      free_head_r   <= '0;
      active_head_r <= END_MARK;
      count_r       <= '0;
      sweep_r       <= '0;
    end else begin
      if (cfg_valid) bsize_r <= cfg_data;
      unique case (cmd.op)
        OP_ALLOC_WR: begin
          free_head_r   <= rdata_r;
          active_head_r <= cur_r;
          count_r       <= count_r + CNT_W'(1);
        end
        OP_UNLINK: begin
          if (!prev_valid) active_head_r <= rdata_r;
        end
        OP_PUSH: begin
          free_head_r <= cur_r;
          if (count_r != '0) count_r <= count_r - CNT_W'(1);
        end
        OP_SWEEP: begin
          if (sts.sweep_last) begin
            sweep_r       <= '0;
            free_head_r   <= '0;
            active_head_r <= END_MARK;
            count_r       <= '0;
          end else begin
            sweep_r <= sweep_r + ADDR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_full[OFS_W-1:0];
    unique case (cmd.op)
      OP_ACCEPT: begin
        want_r   <= in_release_offset;
        status_r <= ST_OK;
        ofs_r    <= '0;
      end
      OP_ALLOC_RD: cur_r <= free_head_r;
      OP_ALLOC_WR: ofs_r <= prod_r;
      OP_WALK_START: begin
        cur_r  <= active_head_r;
        prev_r <= END_MARK;
      end
      OP_WALK_STEP: begin
        prev_r <= cur_r;
        cur_r  <= rdata_r;
      end
      OP_FAIL: status_r <= cmd.fail_code;
      OP_RESP: begin
        out_r.status        <= status_r;
        out_r.block_offset  <= ofs_r;
        out_r.blocks_in_use <= CNT_OUT_W'(count_r);
        out_r.pool_empty    <= (count_r == '0);
        out_r.pool_full     <= (count_r == CNT_MAX);
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("use count above capacity");

  a_free_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < CNT_MAX) |-> (free_head_r < END_MARK))
    else $error("free list empty while blocks remain");

  a_active_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (active_head_r == END_MARK))
    else $error("active list not empty with zero count");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_ALLOC_WR) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("allocate did not bump the count");

endmodule

`default_nettype wire

### rtl/core/fixed_block_pool_allocator.sv
// Allocate: accept, then ALLOC_RD, ALLOC_WR (skipped when full) and RESP; in_ready back with out_valid.
// Release: walks the active list from its head, one link table read per walk step,
//   then unlinks the matching block and pushes it on the free list; a miss returns not found.
// Pool reset request: rewrites every link table entry; an unaccepted result stalls the next item.
// After rst_n the link table is rebuilt entry by entry with in_ready low;
//   configuration writes are taken at once. block_size resets to 64.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with free and active lists in one shared link table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire fbpa_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output fbpa_pkg::out_item_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [fbpa_pkg::BS_W-1:0]  cfg_data
);
  import fbpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .sts         (sts)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .in_release_offset (in_data.release_offset),
    .cmd               (cmd),
    .sts               (sts),
    .out_data          (out_data)
  );

endmodule

`default_nettype wire

### tb/fbpa_checker.sv
// ----------------------------------------------------------------------------
// fbpa_checker
// Watches the request, reply and block size channels of the block pool
// allocator, keeps its own copy of the free and active lists, and compares
// every reply with the one expected for the oldest open request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpa_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  fbpa_pkg::in_item_t        in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  fbpa_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [fbpa_pkg::BS_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);

  import fbpa_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;

  logic [BS_W-1:0]      blk_size;
  logic [5:0]           next_of [NBLK];
  logic [5:0]           free_hd;
  logic [5:0]           active_hd;
  logic [CNT_OUT_W-1:0] in_use;
  out_item_t            pool_replies [$];

  function automatic logic [OFS_W-1:0] byte_offset(input int idx);
    logic [31:0] prod;
    prod = idx * blk_size;
    return prod[OFS_W-1:0];
  endfunction

  function automatic void rebuild_lists();
    for (int i = 0; i < NBLK; i++) next_of[i] = 6'(i + 1);
    free_hd   = '0;
    active_hd = 6'(NBLK);
    in_use    = '0;
  endfunction

  // applies one request to the shadow lists and returns the reply it should get
  function automatic out_item_t serve_request(input in_item_t rq);
    out_item_t r;
    int        cur;
    int        prv;
    int        steps;
    bit        hit;
    r = '0;
    case (rq.req_type)
      REQ_ALLOC: begin
        if (in_use >= NBLK || free_hd >= NBLK) begin
          r.status = ST_FULL;
        end else begin
          cur            = free_hd;
          free_hd        = next_of[cur];
          next_of[cur]   = active_hd;
          active_hd      = 6'(cur);
          in_use         = in_use + 1'b1;
          r.block_offset = byte_offset(cur);
        end
      end
      REQ_RELEASE: begin
        cur   = active_hd;
        prv   = NBLK;
        steps = 0;
        hit   = 1'b0;
        while (cur < NBLK && steps < NBLK && !hit) begin
          if (byte_offset(cur) == rq.release_offset) begin
            hit = 1'b1;
          end else begin
            prv   = cur;
            cur   = next_of[cur];
            steps = steps + 1;
          end
        end
        if (hit) begin
          if (prv < NBLK) next_of[prv] = next_of[cur];
          else active_hd = next_of[cur];
          next_of[cur] = free_hd;
          free_hd      = 6'(cur);
          if (in_use > 0) in_use = in_use - 1'b1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      REQ_RESET: rebuild_lists();
      default: ;
    endcase
    r.blocks_in_use = in_use;
    r.pool_empty    = (in_use == 0);
    r.pool_full     = (in_use == NBLK);
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count = fail_count + 1;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      rebuild_lists();
      blk_size   = BS_RESET;
      pool_replies.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pool_replies.size() == 0) begin
          $error("reply with no request open: %p", out_data);
          fail_count = fail_count + 1;
        end else begin
          want = pool_replies.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("block_offset", want.block_offset, out_data.block_offset);
          check_field("blocks_in_use", want.blocks_in_use, out_data.blocks_in_use);
          check_field("pool_empty", want.pool_empty, out_data.pool_empty);
          check_field("pool_full", want.pool_full, out_data.pool_full);
        end
      end
      if (cfg_valid && cfg_ready) blk_size = cfg_data;
      if (in_valid && in_ready) pool_replies.push_back(serve_request(in_data));
      pending = pool_replies.size();
    end
  end

endmodule

### tb/tb_fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator
// Drives allocate, release and pool reset requests into the block pool
// allocator over a series of block sizes, with random idling on both sides;
// the checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;

  import fbpa_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int               WD_LIMIT    = 1000;
  localparam int               PHASE_ITEMS = 143;
  localparam int               NUM_PHASES  = 9;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [BS_W-1:0] cfg_data;

  int              fail_count;
  int              pending;
  int              gap_pct;
  int              stall_pct;
  int              stall_left;
  int              idle_cycles;
  logic [BS_W-1:0] cur_bs;

  fixed_block_pool_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fbpa_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reply side drops out_ready in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [OFS_W-1:0] any_offset();
    return OFS_W'($urandom_range(0, (1 << OFS_W) - 1));
  endfunction

  // mostly offsets of real blocks at the current size, sometimes anything
  function automatic logic [OFS_W-1:0] release_target();
    logic [31:0] prod;
    if ($urandom_range(0, 6) == 0) return any_offset();
    prod = $urandom_range(0, MAX_BLOCKS_DEF - 1) * cur_bs;
    return prod[OFS_W-1:0];
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [OFS_W-1:0] ofs);
    in_item_t it;
    it.req_type       = kind;
    it.release_offset = ofs;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [BS_W-1:0] bs);
    cfg_valid <= 1'b1;
    cfg_data  <= bs;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_bs = bs;
  endtask

  // mode 0 fills the pool, mode 1 drains it, mode 2 mixes both
  task automatic random_req(input int mode);
    int r;
    int alloc_pct;
    r         = $urandom_range(0, 99);
    alloc_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 50;
    if (r < 1) send_req(REQ_RESET, any_offset());
    else if (r < 3) send_req(REQ_UNKNOWN, any_offset());
    else if (r < 3 + alloc_pct) send_req(REQ_ALLOC, any_offset());
    else send_req(REQ_RELEASE, release_target());
  endtask

  task automatic run_phase(input logic [BS_W-1:0] bs, input int gp, input int sp);
    int sent;
    int blen;
    int mode;
    drain_replies();
    write_block_size(bs);
    gap_pct   = gp;
    stall_pct = sp;
    // clean pool, then fill past capacity so the full case is always reached
    send_req(REQ_RESET, any_offset());
    repeat (MAX_BLOCKS_DEF + 2) send_req(REQ_ALLOC, any_offset());
    sent = MAX_BLOCKS_DEF + 3;
    while (sent < PHASE_ITEMS) begin
      mode = $urandom_range(0, 2);
      blen = $urandom_range(20, 60);
      for (int i = 0; i < blen && sent < PHASE_ITEMS; i++) begin
        random_req(mode);
        sent++;
      end
    end
  endtask

  initial begin
    logic [BS_W-1:0] bs;
    int              gp;
    int              sp;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    out_ready  = 1'b0;
    stall_left = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    cur_bs     = BS_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // short directed run at the reset block size
    send_req(REQ_RELEASE, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '1);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, 17'd64);
    send_req(REQ_RELEASE, 17'd128);
    send_req(REQ_RELEASE, 17'd0);
    send_req(REQ_UNKNOWN, '1);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, '1);
    send_req(REQ_RESET, '1);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, 17'd126976);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: bs = 13'd64;
        1: bs = 13'd0;
        2: bs = 13'd1;
        3: bs = 13'd8191;
        4: bs = 13'd4096;
        5: bs = 13'd4097;
        6: bs = 13'd3;
        7: bs = BS_W'($urandom_range(1, 4096));
        default: bs = 13'd64;
      endcase
      case ($urandom_range(0, 2))
        0: gp = 0;
        1: gp = 10;
        default: gp = 35;
      endcase
      case ($urandom_range(0, 2))
        0: sp = 0;
        1: sp = 10;
        default: sp = 35;
      endcase
      // last phase runs without idling
      if (p == NUM_PHASES - 1) begin
        gp = 0;
        sp = 0;
      end
      run_phase(bs, gp, sp);
    end

    drain_replies();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
